// File: hdl/rpvs_pkg.sv
// Shared types and constants for the ramped phasor voltage source.
// Depends on nothing; used by the CORDIC stage and the top level.
`default_nettype none
package rpvs_pkg;
    localparam int ANG_W = 32;
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };
    typedef enum logic [2:0] {
        REG_VREF_RE = 3'd0, REG_VREF_IM = 3'd1, REG_DV_RE = 3'd2, REG_DV_IM = 3'd3,
        REG_RATE = 3'd4, REG_SWITCH = 3'd5, REG_RAMP = 3'd6, REG_RECIP = 3'd7
    } reg_idx_t;
endpackage
`default_nettype wire

// File: hdl/rpvs_cordic_stage.sv
// One registered CORDIC micro-rotation with a pipeline enable.
// Depends on rpvs_pkg for the arctangent table.
`default_nettype none
module rpvs_cordic_stage #(
    parameter int W = 64,
    parameter int IDX = 0
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] x_in,
    input  wire logic [W-1:0] y_in,
    input  wire logic [33:0]  z_in,
    output logic [W-1:0]      x_out,
    output logic [W-1:0]      y_out,
    output logic [33:0]       z_out
);
    logic signed [W-1:0] xs, ys;
    logic [33:0] at;
    assign xs = $signed(x_in) >>> IDX;
    assign ys = $signed(y_in) >>> IDX;
    assign at = {2'b00, rpvs_pkg::ATAN_TURNS[IDX]};
    always_ff @(posedge aclk) begin
        if (en) begin
            if (!z_in[33]) begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - at;
            end else begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + at;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/ramped_phasor_voltage_source_top.sv
// Top level of the ramped phasor voltage source: register file, ramp and fade path,
// output rotation. Depends on rpvs_pkg and rpvs_cordic_stage.
`default_nettype none
// Takes one time word per cycle and returns one phasor word per cycle while
// the output is not stalled. The latency comes from two CORDIC pipelines
// in series (fade cosine, then output rotation) and the multiplier stages
// around them. The whole pipeline advances when the output register is
// empty or being taken, so a stall loses nothing.
module ramped_phasor_voltage_source_top #(
    parameter int TIME_FRAC = 24,
    parameter int VOLT_WIDTH = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [47:0]             s_tdata,   // sim_time
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [2*VOLT_WIDTH-1:0]      m_tdata,   // v_re, v_im
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [63:0]             cfg_data
);
    localparam int VW = VOLT_WIDTH;
    localparam int CW = 64;
    localparam int NS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int LAT = 2 * NS + 12;

    function automatic logic [63:0] gain_root_f();
        logic [63:0] g, r, bitv, n;
        g = 64'd1 << 60;
        for (int i = 0; i < NS; i++) g = g + (g >> (2 * i));
        n = g; r = 0; bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv); r = (r >> 1) + bitv;
            end else r = r >> 1;
            bitv = bitv >> 2;
        end
        if (r == 0) r = 1;
        return r;
    endfunction
    localparam logic [63:0] GAIN_ROOT = gain_root_f();
    localparam logic [63:0] KINV_FULL = (64'd1 << 62) / GAIN_ROOT;
    localparam logic [31:0] KINV = (KINV_FULL > 64'hFFFFFFFF) ? 32'hFFFFFFFF
                                                              : KINV_FULL[31:0];

    function automatic logic signed [VW-1:0] sat_f(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] hi, lo;
        hi = (CW'(1) <<< (VW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[VW-1:0];
        if (v < lo) return lo[VW-1:0];
        return v[VW-1:0];
    endfunction

    logic signed [VW-1:0] vref_re_reg, vref_im_reg, dv_re_reg, dv_im_reg;
    logic signed [31:0] rate_reg;
    logic [47:0] switch_reg, ramp_reg;
    logic [56:0] recip_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_re_reg <= '0; vref_im_reg <= '0; dv_re_reg <= '0; dv_im_reg <= '0;
            rate_reg <= '0; switch_reg <= '0; ramp_reg <= '0; recip_reg <= '0;
        end else if (cfg_valid) begin
            case (rpvs_pkg::reg_idx_t'(cfg_index))
                rpvs_pkg::REG_VREF_RE: vref_re_reg <= cfg_data[VW-1:0];
                rpvs_pkg::REG_VREF_IM: vref_im_reg <= cfg_data[VW-1:0];
                rpvs_pkg::REG_DV_RE:   dv_re_reg <= cfg_data[VW-1:0];
                rpvs_pkg::REG_DV_IM:   dv_im_reg <= cfg_data[VW-1:0];
                rpvs_pkg::REG_RATE:    rate_reg <= cfg_data[31:0];
                rpvs_pkg::REG_SWITCH:  switch_reg <= cfg_data[47:0];
                rpvs_pkg::REG_RAMP:    ramp_reg <= cfg_data[47:0];
                rpvs_pkg::REG_RECIP:   recip_reg <= cfg_data[56:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    typedef struct packed {
        logic [47:0] t;
        logic        pre;
        logic        ramp;
    } tag_t;

    // Stage 1: time offset and window compare.
    logic [47:0] d_s1_reg, t_s1_reg;
    logic pre_s1_reg, ramp_s1_reg;
    logic [47:0] d_w;
    assign d_w = s_tdata - switch_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            t_s1_reg <= s_tdata;
            d_s1_reg <= d_w;
            pre_s1_reg <= s_tdata < switch_reg;
            ramp_s1_reg <= d_w < ramp_reg;
        end
    end

    // Stages 2-3: d * recip split in 24x29-bit and 24x28-bit partial products.
    logic [52:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    tag_t tg2_reg, tg3_reg, tg4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= 53'(d_s1_reg[23:0]) * 53'(recip_reg[28:0]);
            pp_lh_reg <= 53'(d_s1_reg[23:0]) * 53'(recip_reg[56:29]);
            pp_hl_reg <= 53'(d_s1_reg[47:24]) * 53'(recip_reg[28:0]);
            pp_hh_reg <= 53'(d_s1_reg[47:24]) * 53'(recip_reg[56:29]);
            tg2_reg <= '{t: t_s1_reg, pre: pre_s1_reg, ramp: ramp_s1_reg};
        end
    end
    logic [105:0] prod_s3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_s3_reg <= 106'(pp_ll_reg) + (106'(pp_lh_reg) << 29)
                         + (106'(pp_hl_reg) << 24) + (106'(pp_hh_reg) << 53);
            tg3_reg <= tg2_reg;
        end
    end

    // Stage 4: fraction with clamp.
    logic [15:0] f_s4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            f_s4_reg <= (prod_s3_reg[105:56] != 0) ? 16'hFFFF : prod_s3_reg[55:40];
            tg4_reg <= tg3_reg;
        end
    end

    // Stage 5: ramped phasor and cosine CORDIC input.
    logic signed [VW-1:0] pr5_reg, pi5_reg;
    logic [CW-1:0] cx0_reg, cy0_reg;
    logic [33:0] cz0_reg;
    tag_t tg5_reg;
    logic signed [CW-1:0] fr_w, fi_w;
    logic [31:0] ca_w, ca2_w;
    assign fr_w = $signed({1'b0, f_s4_reg}) * $signed(dv_re_reg);
    assign fi_w = $signed({1'b0, f_s4_reg}) * $signed(dv_im_reg);
    assign ca_w = {1'b0, f_s4_reg, 15'd0};
    assign ca2_w = ca_w + 32'h80000000;
    always_ff @(posedge aclk) begin
        if (en) begin
            if (tg4_reg.pre) begin
                pr5_reg <= vref_re_reg; pi5_reg <= vref_im_reg;
            end else if (tg4_reg.ramp) begin
                pr5_reg <= sat_f(CW'(vref_re_reg) + (fr_w >>> 16));
                pi5_reg <= sat_f(CW'(vref_im_reg) + (fi_w >>> 16));
            end else begin
                pr5_reg <= sat_f(CW'(vref_re_reg) + CW'(dv_re_reg));
                pi5_reg <= sat_f(CW'(vref_im_reg) + CW'(dv_im_reg));
            end
            tg5_reg <= tg4_reg;
            if (32'(ca_w + 32'h40000000) >= 32'h80000000) begin
                cx0_reg <= -(CW'(1) << 38);
                cz0_reg <= {{2{ca2_w[31]}}, ca2_w};
            end else begin
                cx0_reg <= CW'(1) << 38;
                cz0_reg <= {{2{ca_w[31]}}, ca_w};
            end
            cy0_reg <= '0;
        end
    end

    logic [CW-1:0] cx [NS+1];
    logic [CW-1:0] cy [NS+1];
    logic [33:0]   cz [NS+1];
    assign cx[0] = cx0_reg; assign cy[0] = cy0_reg; assign cz[0] = cz0_reg;
    tag_t tgc [NS+1];
    logic signed [VW-1:0] prc [NS+1];
    logic signed [VW-1:0] pic [NS+1];
    assign tgc[0] = tg5_reg; assign prc[0] = pr5_reg; assign pic[0] = pi5_reg;
    for (genvar i = 0; i < NS; i++) begin : g_cos
        rpvs_cordic_stage #(.W(CW), .IDX(i)) u_stage (
            .aclk(aclk), .en(en), .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
            .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                tgc[i+1] <= tgc[i]; prc[i+1] <= prc[i]; pic[i+1] <= pic[i];
            end
        end
    end

    // Unscale for cosine: two 32x32 partial products, then combine.
    logic [63:0] um_hi_reg, um_lo_reg;
    logic un_neg_reg;
    tag_t tgu_reg, tgf_reg, tgr_reg;
    logic signed [VW-1:0] pru_reg, piu_reg, prf_reg, pif_reg, prr_reg, pir_reg;
    logic [63:0] cmag_w;
    assign cmag_w = cx[NS][CW-1] ? -cx[NS] : cx[NS];
    always_ff @(posedge aclk) begin
        if (en) begin
            um_hi_reg <= cmag_w[63:32] * KINV;
            um_lo_reg <= cmag_w[31:0] * KINV;
            un_neg_reg <= cx[NS][CW-1];
            tgu_reg <= tgc[NS]; pru_reg <= prc[NS]; piu_reg <= pic[NS];
        end
    end
    logic signed [CW-1:0] num_w, cosv_w;
    logic [63:0] ua_w;
    logic [16:0] fade_w;
    assign ua_w = um_hi_reg + (um_lo_reg >> 32);
    assign cosv_w = un_neg_reg ? -$signed(CW'((ua_w + 64'd128) >> 8))
                               : $signed(CW'((ua_w + 64'd128) >> 8));
    assign num_w = (CW'(1) <<< 30) - cosv_w + (CW'(1) <<< 14);
    assign fade_w = num_w[CW-1] ? 17'd0 :
                    ((num_w >>> 15) > 65536) ? 17'd65536 : 17'(num_w >>> 15);
    logic [16:0] fade_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            fade_reg <= tgu_reg.ramp ? fade_w : 17'd65536;
            tgf_reg <= tgu_reg; prf_reg <= pru_reg; pif_reg <= piu_reg;
        end
    end

    // fade * rate, then times t (low 64 bits) in partial products.
    logic [63:0] fr_reg;
    tag_t tgm_reg;
    logic signed [VW-1:0] prm_reg, pim_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg <= 64'($signed({1'b0, fade_reg})) * 64'(rate_reg);
            tgm_reg <= tgf_reg; prm_reg <= prf_reg; pim_reg <= pif_reg;
        end
    end
    logic [63:0] q_ll_reg, q_hl_reg, q_lh_reg;
    tag_t tgq_reg;
    logic signed [VW-1:0] prq_reg, piq_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            q_ll_reg <= fr_reg[31:0] * tgm_reg.t[31:0];
            q_hl_reg <= fr_reg[63:32] * tgm_reg.t[31:0];
            q_lh_reg <= 64'(fr_reg[31:0] * tgm_reg.t[47:32]);
            tgq_reg <= tgm_reg; prq_reg <= prm_reg; piq_reg <= pim_reg;
        end
    end
    logic [63:0] pt_w;
    logic [31:0] ang_w, ang2_w;
    assign pt_w = q_ll_reg + (q_hl_reg << 32) + (q_lh_reg << 32);
    assign ang_w = pt_w[TIME_FRAC+31:TIME_FRAC];
    assign ang2_w = ang_w + 32'h80000000;

    logic [CW-1:0] rx0_reg, ry0_reg;
    logic [33:0] rz0_reg;
    logic signed [CW-1:0] px_w, py_w;
    assign px_w = CW'(prq_reg) <<< 8;
    assign py_w = CW'(piq_reg) <<< 8;
    always_ff @(posedge aclk) begin
        if (en) begin
            tgr_reg <= tgq_reg; prr_reg <= prq_reg; pir_reg <= piq_reg;
            if (32'(ang_w + 32'h40000000) >= 32'h80000000) begin
                rx0_reg <= -px_w; ry0_reg <= -py_w;
                rz0_reg <= {{2{ang2_w[31]}}, ang2_w};
            end else begin
                rx0_reg <= px_w; ry0_reg <= py_w;
                rz0_reg <= {{2{ang_w[31]}}, ang_w};
            end
        end
    end

    logic [CW-1:0] rx [NS+1];
    logic [CW-1:0] ry [NS+1];
    logic [33:0]   rz [NS+1];
    tag_t tgo [NS+1];
    logic signed [VW-1:0] pro [NS+1];
    logic signed [VW-1:0] pio [NS+1];
    assign rx[0] = rx0_reg; assign ry[0] = ry0_reg; assign rz[0] = rz0_reg;
    assign tgo[0] = tgr_reg; assign pro[0] = prr_reg; assign pio[0] = pir_reg;
    for (genvar i = 0; i < NS; i++) begin : g_rot
        rpvs_cordic_stage #(.W(CW), .IDX(i)) u_stage (
            .aclk(aclk), .en(en), .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
            .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                tgo[i+1] <= tgo[i]; pro[i+1] <= pro[i]; pio[i+1] <= pio[i];
            end
        end
    end

    logic [63:0] xm_w, ym_w;
    assign xm_w = rx[NS][CW-1] ? -rx[NS] : rx[NS];
    assign ym_w = ry[NS][CW-1] ? -ry[NS] : ry[NS];
    logic [63:0] xh_reg, xl_reg, yh_reg, yl_reg;
    logic xn_reg, yn_reg;
    tag_t tgz_reg;
    logic signed [VW-1:0] prz_reg, piz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            xh_reg <= xm_w[63:32] * KINV; xl_reg <= xm_w[31:0] * KINV;
            yh_reg <= ym_w[63:32] * KINV; yl_reg <= ym_w[31:0] * KINV;
            xn_reg <= rx[NS][CW-1]; yn_reg <= ry[NS][CW-1];
            tgz_reg <= tgo[NS]; prz_reg <= pro[NS]; piz_reg <= pio[NS];
        end
    end
    logic [63:0] xa_w, ya_w;
    logic signed [CW-1:0] xr_w, yr_w;
    assign xa_w = (xh_reg + (xl_reg >> 32) + 64'd128) >> 8;
    assign ya_w = (yh_reg + (yl_reg >> 32) + 64'd128) >> 8;
    assign xr_w = xn_reg ? -$signed(xa_w) : $signed(xa_w);
    assign yr_w = yn_reg ? -$signed(ya_w) : $signed(ya_w);
    always_ff @(posedge aclk) begin
        if (en) begin
            if (tgz_reg.pre) m_tdata <= {piz_reg, prz_reg};
            else m_tdata <= {sat_f(yr_w), sat_f(xr_w)};
        end
    end
    assign m_tvalid = vld_reg[LAT-1];

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output side");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word lost in pipeline");
`endif
endmodule
`default_nettype wire

// File: tb/sv/ramped_phasor_voltage_source_top_test.sv
// Self-checking testbench for the ramped phasor voltage source top level.
// Depends on rpvs_pkg and the RTL of ramped_phasor_voltage_source_top and rpvs_cordic_stage.
// A scoreboard class predicts each phasor word from the accepted time words.
`default_nettype none
module ramped_phasor_voltage_source_top_test;

    localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned MASK57 = 64'h1FF_FFFF_FFFF_FFFF;
    localparam int LATENCY = 2 * 16 + 12;
    localparam int CYCLE_LIMIT = 3000000;

    class phasor_scoreboard;
        logic [31:0] vref_re = '0, vref_im = '0, dv_re = '0, dv_im = '0, turn_rate = '0;
        logic [47:0] switch_at = '0, ramp_len = '0;
        logic [56:0] ramp_recip = '0;
        logic [63:0] pending[$];
        int errors = 0;

        function void write_reg(rpvs_pkg::reg_idx_t idx, logic [63:0] value);
            case (idx)
                rpvs_pkg::REG_VREF_RE: vref_re = value[31:0];
                rpvs_pkg::REG_VREF_IM: vref_im = value[31:0];
                rpvs_pkg::REG_DV_RE:   dv_re = value[31:0];
                rpvs_pkg::REG_DV_IM:   dv_im = value[31:0];
                rpvs_pkg::REG_RATE:    turn_rate = value[31:0];
                rpvs_pkg::REG_SWITCH:  switch_at = value[47:0];
                rpvs_pkg::REG_RAMP:    ramp_len = value[47:0];
                rpvs_pkg::REG_RECIP:   ramp_recip = value[56:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint unsigned gain_comp();
            longint unsigned g, r, q;
            g = 64'd1 << 60;
            for (int i = 0; i < 16; i++) g = g + (g >> (2 * i));
            r = int_sqrt(g);
            if (r == 0) r = 1;
            q = (64'd1 << 62) / r;
            return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
        endfunction

        function longint descale(longint v, longint unsigned k);
            longint unsigned m, a;
            longint r;
            m = (v < 0) ? longint'(-v) : longint'(v);
            a = (m >> 32) * k + (((m & 64'hFFFF_FFFF) * k) >> 32);
            r = longint'((a + 128) >> 8);
            return (v < 0) ? -r : r;
        endfunction

        function void spin(inout longint x, inout longint y, input logic [31:0] ang);
            longint xs, ys, z, nx;
            longint unsigned k;
            xs = x * 256;
            ys = y * 256;
            k = gain_comp();
            if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
                xs = -xs;
                ys = -ys;
                ang = ang + 32'h8000_0000;
            end
            z = longint'($signed(ang));
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    nx = xs - (ys >>> i);
                    ys = ys + (xs >>> i);
                    z = z - longint'(rpvs_pkg::ATAN_TURNS[i]);
                end else begin
                    nx = xs + (ys >>> i);
                    ys = ys - (xs >>> i);
                    z = z + longint'(rpvs_pkg::ATAN_TURNS[i]);
                end
                xs = nx;
            end
            x = descale(xs, k);
            y = descale(ys, k);
        endfunction

        function logic [63:0] phasor_at(logic [47:0] t);
            longint vr, vi, dr, di, rate, pr, pi, fade, f, cx, cy, num;
            longint unsigned d, prod;
            logic [127:0] p;
            logic [31:0] ang;
            vr = longint'($signed(vref_re));
            vi = longint'($signed(vref_im));
            dr = longint'($signed(dv_re));
            di = longint'($signed(dv_im));
            rate = longint'($signed(turn_rate));
            if (t < switch_at) begin
                pr = vr;
                pi = vi;
            end else begin
                d = 64'(t) - 64'(switch_at);
                if (d < 64'(ramp_len)) begin
                    p = 128'(d) * 128'(ramp_recip);
                    p = p >> 40;
                    f = (p > 128'd65535) ? 65535 : longint'(p[15:0]);
                    pr = clip(vr + ((f * dr) >>> 16));
                    pi = clip(vi + ((f * di) >>> 16));
                    cx = 64'sd1 << 30;
                    cy = 0;
                    spin(cx, cy, 32'(f << 15));
                    num = (64'sd1 << 30) - cx + (64'sd1 << 14);
                    fade = (num < 0) ? 0 : (num >>> 15);
                    if (fade > 65536) fade = 65536;
                end else begin
                    pr = clip(vr + dr);
                    pi = clip(vi + di);
                    fade = 65536;
                end
                prod = longint'(fade * rate) * 64'(t);
                ang = prod[55:24];
                spin(pr, pi, ang);
                pr = clip(pr);
                pi = clip(pi);
            end
            return {pi[31:0], pr[31:0]};
        endfunction

        function void note_time(logic [47:0] t);
            pending = {pending, phasor_at(t)};
        endfunction

        function void check_phasor(logic [63:0] got);
            logic [63:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected phasor word re=%h im=%h", $time, got[31:0],
                         got[63:32]);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[31:0] !== got[31:0]) begin
                $display("%0t: v_re expected %h actual %h", $time, want[31:0], got[31:0]);
                errors++;
            end
            if (want[63:32] !== got[63:32]) begin
                $display("%0t: v_im expected %h actual %h", $time, want[63:32], got[63:32]);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    phasor_scoreboard board = new;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    ramped_phasor_voltage_source_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_phasor(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint unsigned rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic longint unsigned rand_below(longint unsigned n);
        return (n == 0) ? 0 : rand64() % n;
    endfunction

    task automatic write_reg(rpvs_pkg::reg_idx_t idx, longint unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.write_reg(idx, value);
    endtask

    // The 32-bit registers get random upper bits, which the block must ignore.
    task automatic load_setting(longint vr, longint vi, longint dr, longint di, longint rt,
                                longint unsigned sw, longint unsigned rl,
                                longint unsigned rc);
        write_reg(rpvs_pkg::REG_VREF_RE, {$urandom, vr[31:0]});
        write_reg(rpvs_pkg::REG_VREF_IM, {$urandom, vi[31:0]});
        write_reg(rpvs_pkg::REG_DV_RE, {$urandom, dr[31:0]});
        write_reg(rpvs_pkg::REG_DV_IM, {$urandom, di[31:0]});
        write_reg(rpvs_pkg::REG_RATE, {$urandom, rt[31:0]});
        write_reg(rpvs_pkg::REG_SWITCH, sw | (rand64() & ~MASK48));
        write_reg(rpvs_pkg::REG_RAMP, rl | (rand64() & ~MASK48));
        write_reg(rpvs_pkg::REG_RECIP, rc | (rand64() & ~MASK57));
    endtask

    task automatic send_time(longint unsigned t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t[47:0];
        do @(posedge aclk); while (!s_tready);
        board.note_time(t[47:0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending.size() != 0);
    endtask

    function automatic longint unsigned pick_time();
        longint unsigned sw, rl;
        int sel;
        sw = 64'(board.switch_at);
        rl = 64'(board.ramp_len);
        sel = $urandom_range(99);
        if (sel < 45) return (sw + rand_below(rl)) & MASK48;
        if (sel < 60) return (sw + rl + $urandom_range(4) - 2) & MASK48;
        if (sel < 70) return (sw + $urandom_range(4) - 2) & MASK48;
        if (sel < 80) return rand_below(sw + 1);
        if (sel < 88) return (sw + rl + rand64() % 64'h1_0000_0000) & MASK48;
        return rand64() & MASK48;
    endfunction

    task automatic run_phase(int idle_mode, int count);
        case (idle_mode)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 74; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 74; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && idle_mode == 3) drain();
            send_time(pick_time());
        end
        drain();
    endtask

    task automatic directed_edges();
        longint unsigned sw, rl;
        sw = 64'(board.switch_at);
        rl = 64'(board.ramp_len);
        send_time(0);
        send_time(MASK48);
        send_time((sw - 1) & MASK48);
        send_time(sw);
        send_time((sw + 1) & MASK48);
        send_time((sw + rl / 2) & MASK48);
        send_time((sw + rl - 1) & MASK48);
        send_time((sw + rl) & MASK48);
        send_time(64'h5555_5555_5555);
        send_time(64'hAAAA_AAAA_AAAA);
        drain();
    endtask

    initial begin
        longint unsigned rl;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_edges();

        load_setting(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                     64'sd2147483647, 1000, 5000, (64'd1 << 56) / 5000);
        directed_edges();
        run_phase(0, 260);

        // Zero ramp length: the after-ramp rule holds from the switch time on.
        load_setting(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                     -64'sd2147483648, -64'sd2147483648, 0, 0, 0);
        directed_edges();
        run_phase(1, 260);

        rl = 1;
        load_setting(longint'($signed($urandom)), longint'($signed($urandom)),
                     longint'($signed($urandom)), longint'($signed($urandom)),
                     longint'($signed($urandom)), 7, rl, 64'd1 << 56);
        run_phase(2, 200);

        // Reciprocal unrelated to the ramp length, over a huge ramp window.
        load_setting(longint'($signed($urandom)), -64'sd3000, 64'sd2000000,
                     longint'($signed($urandom)), 64'sd65536, 0, MASK48, rand64() & MASK57);
        directed_edges();
        run_phase(3, 260);

        load_setting(64'sd1000, -64'sd1000, longint'($signed($urandom)), 64'sd0,
                     longint'($signed($urandom)), MASK48, rand64() & MASK48,
                     rand64() & MASK57);
        directed_edges();
        run_phase(0, 200);

        for (int k = 0; k < 3; k++) begin
            rl = rand_below(64'd1 << $urandom_range(40, 4)) + 1;
            load_setting(longint'($signed($urandom)), longint'($signed($urandom)),
                         longint'($signed($urandom)), longint'($signed($urandom)),
                         longint'($signed($urandom)), rand64() & MASK48, rl,
                         (64'd1 << 56) / rl);
            run_phase(k + 1, 150);
        end

        repeat (LATENCY + 20) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
